// ===== rtl/oahi_pkg.sv =====
// Shared constants, codes and control structs of the hash insert unit.
package oahi_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int SIZE_W  = $clog2(DEPTH + 1);
	localparam int DIV_W   = IDX_W + 1;
	localparam int SYM_W   = 8;
	localparam int CNT_W   = $clog2(SYM_W);
	localparam int SUM_W   = 16;
	localparam int CFG_SIZE_W = 7;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam int OUT_IDX_W = 6;

	localparam logic [CFG_SIZE_W-1:0] SIZE_RST = 7'd47;

	// register index within the configuration space (paddr[2])
	localparam logic REG_TABLE_SIZE = 1'b0;
	localparam logic REG_PROBE_MODE = 1'b1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_PRESENT  = 2'd1,
		ST_FULL     = 2'd2,
		ST_CLEARED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_KEY,
		S_READ,
		S_CMP,
		S_CLEAR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CFG_SIZE_W-1:0] size;
		logic                  mode;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic div_step;
		logic key_load;
		logic rd_issue;
		logic eval;
		logic probe_adv;
		logic clear;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic hit_empty;
		logic hit_match;
		logic probe_last;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/oahi_in_if.sv =====
// Input channel: operation and symbol words with valid/ready.
interface oahi_in_if;
	logic                   valid;
	logic                   ready;
	logic                   operation;
	logic signed [7:0]      symbol;

	modport source (output valid, operation, symbol, input ready);
	modport sink (input valid, operation, symbol, output ready);
endinterface

// ===== rtl/oahi_out_if.sv =====
// Output channel: insert result words with valid/ready.
interface oahi_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  probe_count;
	logic [5:0]  slot_index;
	logic [15:0] probe_total;

	modport source (output valid, status, probe_count, slot_index, probe_total, input ready);
	modport sink (input valid, status, probe_count, slot_index, probe_total, output ready);
endinterface

// ===== rtl/oahi_cfg.sv =====
// APB-style configuration registers: table size and probe mode.
module oahi_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [oahi_pkg::ADDR_W-1:0] paddr,
	input  logic [oahi_pkg::DATA_W-1:0] pwdata,
	output logic [oahi_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output oahi_pkg::cfg_t              cfg
);

	logic [oahi_pkg::CFG_SIZE_W-1:0] size_q;
	logic                            mode_q;
	logic                            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= oahi_pkg::SIZE_RST;
			mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[2])
				oahi_pkg::REG_TABLE_SIZE: size_q <= pwdata[oahi_pkg::CFG_SIZE_W-1:0];
				oahi_pkg::REG_PROBE_MODE: mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			oahi_pkg::REG_TABLE_SIZE:
				prdata = oahi_pkg::DATA_W'(size_q);
			oahi_pkg::REG_PROBE_MODE:
				prdata = oahi_pkg::DATA_W'(mode_q);
			default:
				prdata = '0;
		endcase
	end

	assign cfg.size = size_q;
	assign cfg.mode = mode_q;

endmodule

// ===== rtl/oahi_dpath.sv =====
// Datapath: hash remainder unit, probe index stepping, slot memory, result and output registers.
module oahi_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  oahi_pkg::cfg_t       cfg,
	input  oahi_pkg::cmd_t       cmd,
	output oahi_pkg::sts_t       sts,
	input  logic signed [7:0]    in_symbol,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           out_status,
	output logic [5:0]           out_probe_count,
	output logic [5:0]           out_slot_index,
	output logic [15:0]          out_probe_total
);

	localparam int IDX_W  = oahi_pkg::IDX_W;
	localparam int SIZE_W = oahi_pkg::SIZE_W;
	localparam int DIV_W  = oahi_pkg::DIV_W;
	localparam int SYM_W  = oahi_pkg::SYM_W;
	localparam int SUM_W  = oahi_pkg::SUM_W;

	// item registers
	logic [SIZE_W-1:0]         s_q;
	logic                      mode_q;
	logic                      neg_q;
	logic [SYM_W-1:0]          sym_q;
	logic [SYM_W-1:0]          quo_q;
	logic [IDX_W-1:0]          rem_q;
	logic [oahi_pkg::CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0]          idx_q;
	logic [IDX_W-1:0]          d_q;
	logic [IDX_W-1:0]          m_q;

	// slot store
	logic [SYM_W-1:0]          mem_q [oahi_pkg::DEPTH];
	logic [oahi_pkg::DEPTH-1:0] vld_q;
	logic [SYM_W-1:0]          rd_data_q;
	logic                      rd_vld_q;

	// result and output
	logic [SUM_W-1:0]          sum_q;
	oahi_pkg::status_t         res_status_q;
	logic [IDX_W-1:0]          res_m_q;
	logic [IDX_W-1:0]          res_slot_q;
	logic                      out_valid_q;
	logic [1:0]                out_status_q;
	logic [5:0]                out_m_q;
	logic [5:0]                out_slot_q;
	logic [SUM_W-1:0]          out_sum_q;

	logic [SIZE_W-1:0]         s_act;
	logic [SYM_W-1:0]          mag;
	logic [DIV_W-1:0]          div_t;
	logic [DIV_W-1:0]          div_s;
	logic [IDX_W-1:0]          rem_n;
	logic [IDX_W-1:0]          key;
	logic [IDX_W-1:0]          d_init;
	logic [DIV_W-1:0]          idx_sum;
	logic [IDX_W-1:0]          idx_n;
	logic [DIV_W-1:0]          d1;
	logic [DIV_W-1:0]          d2;
	logic [DIV_W-1:0]          d3;
	logic [SYM_W-1:0]          slot_v;
	logic                      hit_empty;
	logic                      hit_match;
	logic                      probe_last;
	logic                      wr_en;
	logic [SUM_W:0]            sum_add;

	// clamp size to 1 .. DEPTH
	always_comb begin
		priority if (cfg.size == '0)
			s_act = SIZE_W'(1);
		else if (int'(cfg.size) > oahi_pkg::DEPTH)
			s_act = SIZE_W'(oahi_pkg::DEPTH);
		else
			s_act = SIZE_W'(cfg.size);
	end

	assign mag = in_symbol[SYM_W-1] ? (SYM_W'(0) - unsigned'(in_symbol)) : unsigned'(in_symbol);

	// restoring remainder, one dividend bit per cycle
	assign div_s = DIV_W'(s_q);
	assign div_t = {rem_q, quo_q[SYM_W-1]};
	assign rem_n = (div_t >= div_s) ? IDX_W'(div_t - div_s) : IDX_W'(div_t);

	// negative symbols fold back to a non-negative residue
	assign key    = (neg_q && rem_q != '0) ? IDX_W'(s_q - SIZE_W'(rem_q)) : rem_q;
	assign d_init = (s_q == SIZE_W'(1)) ? '0 : IDX_W'(1);

	// idx and step d both stay below s, so one subtract reduces the index sum; the step sum d + 2 takes up to two
	assign idx_sum = DIV_W'(idx_q) + DIV_W'(d_q);
	assign idx_n   = (idx_sum >= div_s) ? IDX_W'(idx_sum - div_s) : IDX_W'(idx_sum);
	assign d1      = DIV_W'(d_q) + DIV_W'(2);
	assign d2      = (d1 >= div_s) ? (d1 - div_s) : d1;
	assign d3      = (d2 >= div_s) ? (d2 - div_s) : d2;

	assign slot_v     = rd_vld_q ? rd_data_q : '0;
	assign hit_empty  = (slot_v == '0);
	assign hit_match  = (slot_v == sym_q);
	assign probe_last = (m_q == IDX_W'(s_q - SIZE_W'(1)));
	assign wr_en      = cmd.eval && hit_empty;
	assign sum_add    = (SUM_W+1)'(sum_q) + (SUM_W+1)'(m_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			s_q    <= s_act;
			mode_q <= cfg.mode;
			sym_q  <= unsigned'(in_symbol);
			neg_q  <= in_symbol[SYM_W-1];
			quo_q  <= mag;
			rem_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[SYM_W-2:0], 1'b0};
		end
		if (cmd.key_load) begin
			idx_q <= key;
			d_q   <= d_init;
			m_q   <= '0;
		end
		if (cmd.probe_adv) begin
			idx_q <= idx_n;
			m_q   <= m_q + IDX_W'(1);
			if (mode_q) begin
				d_q <= IDX_W'(d3);
			end
		end
		if (cmd.eval) begin
			priority if (hit_empty) begin
				res_status_q <= oahi_pkg::ST_INSERTED;
				res_m_q      <= m_q;
				res_slot_q   <= idx_q;
			end else if (hit_match) begin
				res_status_q <= oahi_pkg::ST_PRESENT;
				res_m_q      <= '0;
				res_slot_q   <= '0;
			end else begin
				res_status_q <= oahi_pkg::ST_FULL;
				res_m_q      <= '0;
				res_slot_q   <= '0;
			end
		end
		if (cmd.clear) begin
			res_status_q <= oahi_pkg::ST_CLEARED;
			res_m_q      <= '0;
			res_slot_q   <= '0;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_m_q      <= 6'(res_m_q);
			out_slot_q   <= 6'(res_slot_q);
			out_sum_q    <= sum_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[idx_q] <= sym_q;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				vld_q <= '0;
				sum_q <= '0;
			end else if (wr_en) begin
				vld_q[idx_q] <= 1'b1;
				sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
			end
			if (cmd.rd_issue) begin
				rd_vld_q <= vld_q[idx_q];
			end
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + oahi_pkg::CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.div_last   = (cnt_q == oahi_pkg::CNT_W'(SYM_W - 1));
	assign sts.hit_empty  = hit_empty;
	assign sts.hit_match  = hit_match;
	assign sts.probe_last = probe_last;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_probe_count = out_m_q;
	assign out_slot_index  = out_slot_q;
	assign out_probe_total = out_sum_q;

`ifndef NO_ASSERTIONS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> (DIV_W'(idx_q) < div_s))
		else $error("probe index outside active table");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_adv |=> (DIV_W'(d_q) < DIV_W'(s_q)))
		else $error("probe step not reduced below size");

	a_sum_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.clear |=> (sum_q >= $past(sum_q)))
		else $error("probe total decreased without clear");
`endif

endmodule

// ===== rtl/oahi_ctrl.sv =====
// Controller: sequences remainder, probe walk, clear and result hand-off.
module oahi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_operation,
	output logic           in_ready,
	input  oahi_pkg::sts_t sts,
	output oahi_pkg::cmd_t cmd
);

	oahi_pkg::state_t state_q;
	oahi_pkg::state_t state_n;
	logic             probe_end;

	assign probe_end = sts.hit_empty || sts.hit_match || sts.probe_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oahi_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			oahi_pkg::S_IDLE: begin
				if (in_valid) begin
					state_n = (in_operation == oahi_pkg::OP_CLEAR) ? oahi_pkg::S_CLEAR
					                                               : oahi_pkg::S_DIV;
				end
			end
			oahi_pkg::S_DIV: begin
				if (sts.div_last) begin
					state_n = oahi_pkg::S_KEY;
				end
			end
			oahi_pkg::S_KEY:   state_n = oahi_pkg::S_READ;
			oahi_pkg::S_READ:  state_n = oahi_pkg::S_CMP;
			oahi_pkg::S_CMP:   state_n = probe_end ? oahi_pkg::S_DONE : oahi_pkg::S_READ;
			oahi_pkg::S_CLEAR: state_n = oahi_pkg::S_DONE;
			oahi_pkg::S_DONE: begin
				if (sts.out_free) begin
					state_n = oahi_pkg::S_IDLE;
				end
			end
			default: state_n = oahi_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			oahi_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			oahi_pkg::S_DIV:   cmd.div_step = 1'b1;
			oahi_pkg::S_KEY:   cmd.key_load = 1'b1;
			oahi_pkg::S_READ:  cmd.rd_issue = 1'b1;
			oahi_pkg::S_CMP: begin
				cmd.eval      = 1'b1;
				cmd.probe_adv = !probe_end;
			end
			oahi_pkg::S_CLEAR: cmd.clear = 1'b1;
			oahi_pkg::S_DONE:  cmd.load_out = sts.out_free;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oahi_pkg::S_CMP) |-> ($past(state_q) == oahi_pkg::S_READ))
		else $error("compare without a preceding slot read");

	a_key_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oahi_pkg::S_KEY) |-> ($past(state_q) == oahi_pkg::S_DIV))
		else $error("key load without remainder pass");
`endif

endmodule

// ===== rtl/open_addressing_hash_insert_unit.sv =====
// Open-addressed hash table insert unit: top level.
//
// in_ch carries one word per operation: insert a signed byte symbol, or clear
// the whole table and the probe total. out_ch returns one result word per
// input word: status, probe step, slot written and the saturating probe total.
// The user must write table_size (0x0) and probe_mode (0x4) over the APB port
// only while the unit is idle; the block itself does not enforce it.
// An insert runs after the accepting edge: the remainder pass (one dividend
// bit per cycle over all 8 bits), the key load, then per probe a slot memory
// read and a compare, up to all 64 slots, then the load into the output
// register. A clear runs its clear step, then that load. One word is in work
// at a time and the next is taken only once the result has loaded; the
// probe walk over the single memory read port sets the rate.
// Reset empties the table (per-slot valid bits), zeroes the probe total and
// loads table_size 47, linear probing.
// A result waits in the output register while out_ch is stalled; the next
// input word is accepted meanwhile and its result holds until the register
// frees.
module open_addressing_hash_insert_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	oahi_in_if.sink                     in_ch,
	oahi_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [oahi_pkg::ADDR_W-1:0] paddr,
	input  logic [oahi_pkg::DATA_W-1:0] pwdata,
	output logic [oahi_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	oahi_pkg::cfg_t cfg;
	oahi_pkg::cmd_t cmd;
	oahi_pkg::sts_t sts;

	oahi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	oahi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_operation (in_ch.operation),
		.in_ready     (in_ch.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	oahi_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.in_symbol       (in_ch.symbol),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.out_status      (out_ch.status),
		.out_probe_count (out_ch.probe_count),
		.out_slot_index  (out_ch.slot_index),
		.out_probe_total (out_ch.probe_total)
	);

endmodule
